// ----- src/ecsr_pkg.sv -----
package ecsr_pkg;

  localparam int MAX_EDGES_DEF    = 4096;
  localparam int MAX_VERTICES_DEF = 8192;

  localparam int ID_W     = 32;
  localparam int WT_W     = 8;
  localparam int IDX_W    = 13;
  localparam int STATUS_W = 3;
  localparam int VCNT_W   = 14;
  localparam int ECNT_W   = 13;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 128;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_BUILD = 2'd1,
    REQ_ROW   = 2'd2,
    REQ_SLOT  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_NO_EDGES = 3'd2,
    STS_REPEAT   = 3'd3,
    STS_BAD_READ = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_BUILD,
    S_RANK_SCAN,
    S_RANK_END,
    S_EDGE_SCAN,
    S_EDGE_END,
    S_READ_ADDR,
    S_READ_DATA,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    vertex_id;
    logic [IDX_W-1:0]   offset_begin;
    logic [IDX_W-1:0]   offset_end;
    logic [IDX_W-1:0]   degree;
    logic [IDX_W-1:0]   target_index;
    logic [WT_W-1:0]    edge_weight;
    logic [VCNT_W-1:0]  vertex_count;
    logic [ECNT_W-1:0]  edge_count;
  } result_t;

endpackage

// ----- src/ecsr_out_reg.sv -----
module ecsr_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  ecsr_pkg::result_t                 data,
  output logic                              free,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // status, vertex_id, offset_begin, offset_end, degree, target_index,
  // edge_weight, vertex_count, edge_count, zero pad
  output logic [ecsr_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic              valid_r;
  ecsr_pkg::result_t data_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {6'd0, data_r.edge_count, data_r.vertex_count, data_r.edge_weight,
                       data_r.target_index, data_r.degree, data_r.offset_end,
                       data_r.offset_begin, data_r.vertex_id, data_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data;
    end
  end

endmodule

// ----- src/edge_list_to_csr_builder_unit.sv -----
// Channel   Dir  Group                        Contents
// in_       in   tvalid tready tdata tuser     request word, kind in tuser
// out_      out  tvalid tready tdata           one result word per request
//
// Build: ranks the distinct ids, then orders the edges; one 32-bit compare unit
// ranks ids, one key compare unit orders edges.
// Reset clears counts and graph state only; stores need no clearing pass.
// A waiting result stalls the block in its last state until out_tready.
module edge_list_to_csr_builder_unit #(
  parameter int MAX_EDGES    = ecsr_pkg::MAX_EDGES_DEF,
  parameter int MAX_VERTICES = ecsr_pkg::MAX_VERTICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // first_id, second_id, weight, index, zero pad
  input  logic [ecsr_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, vertex_id, offset_begin, offset_end, degree, target_index,
  // edge_weight, vertex_count, edge_count, zero pad
  output logic [ecsr_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int EA   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW   = $clog2(MAX_EDGES + 1);
  localparam int VA   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VW   = $clog2(MAX_VERTICES + 1);
  localparam int KW   = 2 * VA + ecsr_pkg::WT_W;
  localparam int VCW  = (VW > ecsr_pkg::IDX_W) ? VW : ecsr_pkg::IDX_W + 1;
  localparam int ECW  = (EW > ecsr_pkg::IDX_W) ? EW : ecsr_pkg::IDX_W + 1;

  logic [31:0] mem_first  [MAX_EDGES];
  logic [31:0] mem_second [MAX_EDGES];
  logic [7:0]  mem_wt     [MAX_EDGES];
  logic [VA-1:0] mem_ra   [MAX_EDGES];
  logic [VA-1:0] mem_rb   [MAX_EDGES];
  logic [VA-1:0] mem_tgt  [MAX_EDGES];
  logic [7:0]  mem_awt    [MAX_EDGES];
  logic [31:0] mem_vid    [MAX_VERTICES];
  logic [EW-1:0] mem_obeg [MAX_VERTICES];
  logic [EW-1:0] mem_oend [MAX_VERTICES];
  logic [EW-1:0] mem_deg  [MAX_VERTICES];

  ecsr_pkg::state_t st_r, st_nxt;
  ecsr_pkg::req_t   req_r, req_nxt;
  logic [31:0]      first_r, first_nxt, second_r, second_nxt;
  logic [7:0]       wt_r, wt_nxt;
  logic [12:0]      idx_r, idx_nxt;
  logic [EW-1:0]    ecnt_r, ecnt_nxt;
  logic [VW-1:0]    vcnt_r, vcnt_nxt;
  logic             gvalid_r, gvalid_nxt;
  logic [EW-1:0]    scan_r, scan_nxt;
  logic             pvalid_r, pvalid_nxt;
  logic [EA-1:0]    pidx_r, pidx_nxt;
  logic [31:0]      last_r, last_nxt, best_r, best_nxt;
  logic             last_v_r, last_v_nxt, found_r, found_nxt;
  logic [EW-1:0]    deg_r, deg_nxt, src_r, src_nxt, run_r, run_nxt;
  logic [VA-1:0]    rank_r, rank_nxt;
  logic [EW-1:0]    slot_r, slot_nxt;
  logic [KW-1:0]    lastk_r, lastk_nxt, bestk_r, bestk_nxt;
  logic             lastk_v_r, lastk_v_nxt, dup_r, dup_nxt;
  ecsr_pkg::result_t res_r, res_nxt, res_out;

  logic [31:0]   rd_first_r, rd_second_r, rd_vid_r;
  logic [7:0]    rd_wt_r, rd_awt_r;
  logic [VA-1:0] rd_ra_r, rd_rb_r, rd_tgt_r;
  logic [EW-1:0] rd_obeg_r, rd_oend_r, rd_deg_r;

  logic          in_acc, out_free, out_load, full;
  logic [EA-1:0] ld_addr, scan_addr;
  logic          ld_we, ra_we, rb_we, v_we, e_we;
  logic          c1, c2, tv;
  logic [31:0]   t;
  logic [VA-1:0] lo, hi;
  logic [KW-1:0] k;
  logic          kc;

  assign in_tready = (st_r == ecsr_pkg::S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = !gvalid_r && (ecnt_r == EW'(MAX_EDGES));
  assign ld_addr   = gvalid_r ? '0 : ecnt_r[EA-1:0];
  assign scan_addr = scan_r[EA-1:0];
  assign ld_we     = (st_r == ecsr_pkg::S_LOAD) && !full;
  assign ra_we     = (st_r == ecsr_pkg::S_RANK_SCAN) && pvalid_r && last_v_r &&
                     (rd_first_r == last_r);
  assign rb_we     = (st_r == ecsr_pkg::S_RANK_SCAN) && pvalid_r && last_v_r &&
                     (rd_second_r == last_r);
  assign v_we      = (st_r == ecsr_pkg::S_RANK_END) && last_v_r;
  assign e_we      = (st_r == ecsr_pkg::S_EDGE_END) && !dup_r;
  assign out_load  = (st_r == ecsr_pkg::S_RESP) && out_free;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      mem_first[ld_addr]  <= first_r;
      mem_second[ld_addr] <= second_r;
      mem_wt[ld_addr]     <= wt_r;
    end
    rd_first_r  <= mem_first[scan_addr];
    rd_second_r <= mem_second[scan_addr];
    rd_wt_r     <= mem_wt[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (ra_we) begin
      mem_ra[pidx_r] <= rank_r;
    end
    if (rb_we) begin
      mem_rb[pidx_r] <= rank_r;
    end
    rd_ra_r <= mem_ra[scan_addr];
    rd_rb_r <= mem_rb[scan_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      mem_tgt[slot_r[EA-1:0]] <= bestk_r[KW-VA-1:8];
      mem_awt[slot_r[EA-1:0]] <= bestk_r[7:0];
    end
    rd_tgt_r <= mem_tgt[EA'(idx_r)];
    rd_awt_r <= mem_awt[EA'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      mem_vid[rank_r]  <= last_r;
      mem_obeg[rank_r] <= run_r;
      mem_oend[rank_r] <= run_r + src_r;
      mem_deg[rank_r]  <= deg_r;
    end
    rd_vid_r  <= mem_vid[VA'(idx_r)];
    rd_obeg_r <= mem_obeg[VA'(idx_r)];
    rd_oend_r <= mem_oend[VA'(idx_r)];
    rd_deg_r  <= mem_deg[VA'(idx_r)];
  end

  // rank scan compare unit
  always_comb begin
    c1 = !last_v_r || (rd_first_r > last_r);
    c2 = !last_v_r || (rd_second_r > last_r);
    tv = c1 || c2;
    if (c1 && c2) begin
      t = (rd_first_r < rd_second_r) ? rd_first_r : rd_second_r;
    end else if (c1) begin
      t = rd_first_r;
    end else begin
      t = rd_second_r;
    end
  end

  // edge key compare unit
  always_comb begin
    lo = (rd_ra_r < rd_rb_r) ? rd_ra_r : rd_rb_r;
    hi = (rd_ra_r < rd_rb_r) ? rd_rb_r : rd_ra_r;
    k  = {lo, hi, rd_wt_r};
    kc = !lastk_v_r || (k > lastk_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ecsr_pkg::S_IDLE: begin
        if (in_acc) begin
          case (ecsr_pkg::req_t'(in_tuser))
            ecsr_pkg::REQ_LOAD:  st_nxt = ecsr_pkg::S_LOAD;
            ecsr_pkg::REQ_BUILD: st_nxt = ecsr_pkg::S_BUILD;
            default:             st_nxt = ecsr_pkg::S_READ_ADDR;
          endcase
        end
      end
      ecsr_pkg::S_LOAD:      st_nxt = ecsr_pkg::S_RESP;
      ecsr_pkg::S_BUILD: begin
        st_nxt = (ecnt_r == '0) ? ecsr_pkg::S_RESP : ecsr_pkg::S_RANK_SCAN;
      end
      ecsr_pkg::S_RANK_SCAN: begin
        if (scan_r == ecnt_r && !pvalid_r) begin
          st_nxt = ecsr_pkg::S_RANK_END;
        end
      end
      ecsr_pkg::S_RANK_END: begin
        if (!found_r) begin
          st_nxt = ecsr_pkg::S_EDGE_SCAN;
        end else if (vcnt_r == VW'(MAX_VERTICES)) begin
          st_nxt = ecsr_pkg::S_RESP;
        end else begin
          st_nxt = ecsr_pkg::S_RANK_SCAN;
        end
      end
      ecsr_pkg::S_EDGE_SCAN: begin
        if (scan_r == ecnt_r && !pvalid_r) begin
          st_nxt = ecsr_pkg::S_EDGE_END;
        end
      end
      ecsr_pkg::S_EDGE_END: begin
        if (dup_r || (slot_r + 1'b1 == ecnt_r)) begin
          st_nxt = ecsr_pkg::S_RESP;
        end else begin
          st_nxt = ecsr_pkg::S_EDGE_SCAN;
        end
      end
      ecsr_pkg::S_READ_ADDR: st_nxt = ecsr_pkg::S_READ_DATA;
      ecsr_pkg::S_READ_DATA: st_nxt = ecsr_pkg::S_RESP;
      ecsr_pkg::S_RESP: begin
        if (out_free) begin
          st_nxt = ecsr_pkg::S_IDLE;
        end
      end
      default: st_nxt = ecsr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_nxt     = req_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    wt_nxt      = wt_r;
    idx_nxt     = idx_r;
    ecnt_nxt    = ecnt_r;
    vcnt_nxt    = vcnt_r;
    gvalid_nxt  = gvalid_r;
    scan_nxt    = scan_r;
    pvalid_nxt  = 1'b0;
    pidx_nxt    = pidx_r;
    last_nxt    = last_r;
    last_v_nxt  = last_v_r;
    best_nxt    = best_r;
    found_nxt   = found_r;
    deg_nxt     = deg_r;
    src_nxt     = src_r;
    run_nxt     = run_r;
    rank_nxt    = rank_r;
    slot_nxt    = slot_r;
    lastk_nxt   = lastk_r;
    lastk_v_nxt = lastk_v_r;
    bestk_nxt   = bestk_r;
    dup_nxt     = dup_r;
    res_nxt     = res_r;
    case (st_r)
      ecsr_pkg::S_IDLE: begin
        if (in_acc) begin
          req_nxt    = ecsr_pkg::req_t'(in_tuser);
          first_nxt  = in_tdata[31:0];
          second_nxt = in_tdata[63:32];
          wt_nxt     = in_tdata[71:64];
          idx_nxt    = in_tdata[84:72];
          res_nxt    = '0;
        end
      end
      ecsr_pkg::S_LOAD: begin
        if (gvalid_r) begin
          gvalid_nxt = 1'b0;
          vcnt_nxt   = '0;
          ecnt_nxt   = EW'(1);
        end else if (full) begin
          res_nxt.status = ecsr_pkg::STS_FULL;
        end else begin
          ecnt_nxt = ecnt_r + 1'b1;
        end
      end
      ecsr_pkg::S_BUILD: begin
        if (ecnt_r == '0) begin
          res_nxt.status = ecsr_pkg::STS_NO_EDGES;
        end else begin
          gvalid_nxt = 1'b0;
          vcnt_nxt   = '0;
          last_v_nxt = 1'b0;
          found_nxt  = 1'b0;
          deg_nxt    = '0;
          src_nxt    = '0;
          run_nxt    = '0;
          scan_nxt   = '0;
        end
      end
      ecsr_pkg::S_RANK_SCAN: begin
        if (scan_r != ecnt_r) begin
          pvalid_nxt = 1'b1;
          pidx_nxt   = scan_addr;
          scan_nxt   = scan_r + 1'b1;
        end
        if (pvalid_r) begin
          if (tv && (!found_r || t < best_r)) begin
            best_nxt  = t;
            found_nxt = 1'b1;
          end
          if (ra_we || rb_we) begin
            deg_nxt = deg_r + 1'b1;
          end
          if ((ra_we && rd_second_r >= last_r) || (rb_we && rd_first_r >= last_r)) begin
            src_nxt = src_r + 1'b1;
          end
        end
      end
      ecsr_pkg::S_RANK_END: begin
        if (last_v_r) begin
          run_nxt = run_r + src_r;
        end
        if (!found_r) begin
          slot_nxt    = '0;
          lastk_v_nxt = 1'b0;
          dup_nxt     = 1'b0;
          scan_nxt    = '0;
        end else if (vcnt_r == VW'(MAX_VERTICES)) begin
          ecnt_nxt       = '0;
          vcnt_nxt       = '0;
          res_nxt.status = ecsr_pkg::STS_FULL;
        end else begin
          last_nxt   = best_r;
          last_v_nxt = 1'b1;
          rank_nxt   = VA'(vcnt_r);
          vcnt_nxt   = vcnt_r + 1'b1;
          found_nxt  = 1'b0;
          deg_nxt    = '0;
          src_nxt    = '0;
          scan_nxt   = '0;
        end
      end
      ecsr_pkg::S_EDGE_SCAN: begin
        if (scan_r != ecnt_r) begin
          pvalid_nxt = 1'b1;
          pidx_nxt   = scan_addr;
          scan_nxt   = scan_r + 1'b1;
        end
        if (pvalid_r && kc) begin
          if (!found_r || k < bestk_r) begin
            dup_nxt   = dup_r || (found_r && k[KW-1:8] == bestk_r[KW-1:8]);
            bestk_nxt = k;
            found_nxt = 1'b1;
          end else if (k[KW-1:8] == bestk_r[KW-1:8]) begin
            dup_nxt = 1'b1;
          end
        end
      end
      ecsr_pkg::S_EDGE_END: begin
        if (dup_r) begin
          ecnt_nxt       = '0;
          vcnt_nxt       = '0;
          res_nxt.status = ecsr_pkg::STS_REPEAT;
        end else begin
          lastk_nxt   = bestk_r;
          lastk_v_nxt = 1'b1;
          slot_nxt    = slot_r + 1'b1;
          found_nxt   = 1'b0;
          scan_nxt    = '0;
          if (slot_r + 1'b1 == ecnt_r) begin
            gvalid_nxt = 1'b1;
          end
        end
      end
      ecsr_pkg::S_READ_DATA: begin
        if (req_r == ecsr_pkg::REQ_ROW) begin
          if (gvalid_r && (VCW'(idx_r) < VCW'(vcnt_r))) begin
            res_nxt.vertex_id    = rd_vid_r;
            res_nxt.offset_begin = 13'(rd_obeg_r);
            res_nxt.offset_end   = 13'(rd_oend_r);
            res_nxt.degree       = 13'(rd_deg_r);
          end else begin
            res_nxt.status = ecsr_pkg::STS_BAD_READ;
          end
        end else begin
          if (gvalid_r && (ECW'(idx_r) < ECW'(ecnt_r))) begin
            res_nxt.target_index = 13'(rd_tgt_r);
            res_nxt.edge_weight  = rd_awt_r;
          end else begin
            res_nxt.status = ecsr_pkg::STS_BAD_READ;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_out              = res_r;
    res_out.vertex_count = 14'(vcnt_r);
    res_out.edge_count   = 13'(ecnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ecsr_pkg::S_IDLE;
      ecnt_r   <= '0;
      vcnt_r   <= '0;
      gvalid_r <= 1'b0;
      pvalid_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      ecnt_r   <= ecnt_nxt;
      vcnt_r   <= vcnt_nxt;
      gvalid_r <= gvalid_nxt;
      pvalid_r <= pvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    wt_r      <= wt_nxt;
    idx_r     <= idx_nxt;
    scan_r    <= scan_nxt;
    pidx_r    <= pidx_nxt;
    last_r    <= last_nxt;
    last_v_r  <= last_v_nxt;
    best_r    <= best_nxt;
    found_r   <= found_nxt;
    deg_r     <= deg_nxt;
    src_r     <= src_nxt;
    run_r     <= run_nxt;
    rank_r    <= rank_nxt;
    slot_r    <= slot_nxt;
    lastk_r   <= lastk_nxt;
    lastk_v_r <= lastk_v_nxt;
    bestk_r   <= bestk_nxt;
    dup_r     <= dup_nxt;
    res_r     <= res_nxt;
  end

  ecsr_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .data       (res_out),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_graph_counts: assert property (@(posedge clk) disable iff (!rst_n)
    gvalid_r |-> (vcnt_r != '0) && (ecnt_r != '0))
    else $error("valid graph with an empty count");

  a_ecnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= EW'(MAX_EDGES))
    else $error("edge count past store depth");

  a_resp_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid && (st_r == ecsr_pkg::S_IDLE))
    else $error("result not presented after push");

  a_edge_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ecsr_pkg::S_EDGE_SCAN) |-> (vcnt_r != '0) && !gvalid_r)
    else $error("edge ordering without ranked vertices");

endmodule
